[sv/lmsf_pkg.sv]
package lmsf_pkg;

  // Panel geometry
  localparam int ROW_WIDTH = 96;
  localparam int ROW_PAIRS = 32;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int BLANK_W   = 6;
  localparam int WORD_W    = 13;

  // RGB565 field masks and drive word bit positions
  localparam logic [15:0] RED_FIELD   = 16'hF800;
  localparam logic [15:0] GREEN_FIELD = 16'h07E0;
  localparam logic [15:0] BLUE_FIELD  = 16'h001F;
  localparam int LATCH_POS = 6;
  localparam int OE_N_POS  = 7;
  localparam int ROW_POS   = 8;

  // Register reset values
  localparam logic [BLANK_W-1:0] BLANK_RESET = 6'd4;
  localparam logic               SWAP_RESET  = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLANK_COLUMNS = 2'd0,
    CFG_SWAP_ADJACENT = 2'd1
  } cfg_reg_t;

  // Job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [15:0] upper_color;
    logic [15:0] bottom_color;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] drive_word;
    logic              row_end;
    logic              frame_end;
  } out_item_t;

  // One word to build: its column, row and the pixel pair that fills it
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [15:0]      top;
    logic [15:0]      bot;
  } job_t;

  // Up to two jobs written by the front in one cycle; job1 only with job0
  typedef struct packed {
    logic push0;
    logic push1;
    job_t job0;
    job_t job1;
  } front_push_t;

  function automatic logic [2:0] color_flags(input logic [15:0] c);
    color_flags = {|(c & BLUE_FIELD), |(c & GREEN_FIELD), |(c & RED_FIELD)};
  endfunction

endpackage

[sv/led_matrix_scan_word_formatter_unit.sv]
// A pair that completes a word writes a job into the queue, and the back end then
// loads it into the output register; with swapping both words enter the queue together.
// Throughput: one pixel pair per cycle, one drive word per cycle while the result
// side pops, set by the single-word back end draining a four-entry job queue.
// Reset (synchronous, rst_n low): counters, held pair, job queue and output
// register clear, blank_columns returns to 4 and swap_adjacent to 1.
module led_matrix_scan_word_formatter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  lmsf_pkg::in_item_t              in_item,
  output logic                            out_empty,
  input  logic                            out_pop,
  output lmsf_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lmsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data
);
  import lmsf_pkg::*;

  logic [BLANK_W-1:0] blank_r;
  logic               swap_r;
  logic               in_accept;
  front_push_t        push;
  logic               q_nonempty, q_take;
  job_t               q_head;

  assign cfg_ready = 1'b1;
  assign in_accept = in_push && !in_full;

  // Write configuration registers on a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_r <= BLANK_RESET;
      swap_r  <= SWAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLANK_COLUMNS: blank_r <= cfg_data[BLANK_W-1:0];
        CFG_SWAP_ADJACENT: swap_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lmsf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .item          (in_item),
    .swap_adjacent (swap_r),
    .push          (push)
  );

  lmsf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (q_take),
    .full     (in_full),
    .nonempty (q_nonempty),
    .head_job (q_head)
  );

  lmsf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (q_nonempty),
    .job           (q_head),
    .blank_columns (blank_r),
    .job_take      (q_take),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_item      (out_item)
  );

endmodule

[sv/lmsf_front.sv]
module lmsf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  lmsf_pkg::in_item_t  item,
  input  logic                swap_adjacent,
  output lmsf_pkg::front_push_t push
);
  import lmsf_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [31:0]      held_r, held_nxt;
  logic             last_col;

  assign last_col = (col_r == COL_W'(ROW_WIDTH - 1));

  // Classify the pair: hold, one word, or two swapped words
  always_comb begin
    push         = '0;
    push.job0    = '{col: col_r, row: row_r, top: item.upper_color, bot: item.bottom_color};
    push.job1    = '{col: col_r, row: row_r, top: held_r[15:0], bot: held_r[31:16]};
    held_nxt     = held_r;
    if (!col_r[0]) begin
      held_nxt = {item.bottom_color, item.upper_color};
      if (!(swap_adjacent && !last_col)) begin
        push.push0 = accept;
      end
    end else if (swap_adjacent) begin
      push.job0.col = col_r - COL_W'(1);
      push.push0    = accept;
      push.push1    = accept;
    end else begin
      push.push0 = accept;
    end
  end

  // Advance column and row counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = (row_r == ROW_W'(ROW_PAIRS - 1)) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (accept) begin
        held_r <= held_nxt;
      end
    end
  end

endmodule

[sv/lmsf_queue.sv]
module lmsf_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lmsf_pkg::front_push_t push,
  input  logic                  pop,
  output logic                  full,
  output logic                  nonempty,
  output lmsf_pkg::job_t        head_job
);
  import lmsf_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] head_r, head_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [QPTR_W-1:0] tail0, tail1;

  // Keep room for a two-job transfer
  assign full     = (count_r > QCNT_W'(QDEPTH - 2));
  assign nonempty = (count_r != '0);
  assign head_job = mem_r[head_r];
  assign tail0    = head_r + count_r[QPTR_W-1:0];
  assign tail1    = tail0 + QPTR_W'(1);

  always_comb begin
    head_nxt  = pop ? head_r + QPTR_W'(1) : head_r;
    count_nxt = count_r + QCNT_W'(push.push0) + QCNT_W'(push.push1) - QCNT_W'(pop);
  end

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[tail0] <= push.job0;
    end
    if (push.push1) begin
      mem_r[tail1] <= push.job1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

[sv/lmsf_back.sv]
module lmsf_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       job_valid,
  input  lmsf_pkg::job_t             job,
  input  logic [lmsf_pkg::BLANK_W-1:0] blank_columns,
  output logic                       job_take,
  output logic                       out_empty,
  input  logic                       out_pop,
  output lmsf_pkg::out_item_t        out_item
);
  import lmsf_pkg::*;

  logic                 valid_r, valid_nxt;
  out_item_t            item_r, item_nxt;
  logic [WORD_W-1:0]    word;
  logic                 latch, oe_on, last_col;
  logic [COL_W:0]       col_plus_blank;

  // Build the drive word for the head job
  always_comb begin
    col_plus_blank = {1'b0, job.col} + (COL_W + 1)'(blank_columns);
    last_col       = (job.col == COL_W'(ROW_WIDTH - 1));
    latch          = (job.col >= COL_W'(ROW_WIDTH - 2));
    oe_on          = (job.col >= COL_W'(blank_columns)) &&
                     (col_plus_blank < (COL_W + 1)'(ROW_WIDTH));
    word           = '0;
    word[2:0]      = color_flags(job.top);
    word[5:3]      = color_flags(job.bot);
    word[LATCH_POS] = latch;
    word[OE_N_POS]  = !oe_on;
    word[WORD_W-1:ROW_POS] = job.row;
    item_nxt.drive_word = word;
    item_nxt.row_end    = last_col;
    item_nxt.frame_end  = last_col && (job.row == ROW_W'(ROW_PAIRS - 1));
  end

  // Load the output register when it is free or being drained
  assign job_take  = job_valid && (!valid_r || out_pop);
  assign valid_nxt = job_take || (valid_r && !out_pop);
  assign out_empty = !valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (job_take) begin
      item_r <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

[dv/led_matrix_scan_word_formatter_unit_test.sv]
module led_matrix_scan_word_formatter_unit_test;
  import lmsf_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_OFF       = 300;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  in_item_t             in_item;
  logic                 out_empty;
  logic                 out_pop;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  // Model state: scan position, held even pair and register copies
  int          pix_col;
  int          pix_row;
  logic [31:0] held_pair_q;
  int          blank_cfg;
  logic        swap_cfg;

  out_item_t expected_words[$];
  int        errors;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_req;

  led_matrix_scan_word_formatter_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Red, green and blue presence flags of one RGB565 color
  function automatic logic [2:0] rgb_present(input logic [15:0] c);
    logic [2:0] f;
    f[0] = (c[15:11] != 5'd0);
    f[1] = (c[10:5] != 6'd0);
    f[2] = (c[4:0] != 5'd0);
    return f;
  endfunction

  function automatic out_item_t build_word(input int col, input logic [15:0] top,
                                           input logic [15:0] bot);
    out_item_t   r;
    logic [12:0] w;
    w = '0;
    w[2:0] = rgb_present(top);
    w[5:3] = rgb_present(bot);
    w[LATCH_POS] = (col + 2 >= ROW_WIDTH);
    w[OE_N_POS] = !(col >= blank_cfg && col + blank_cfg < ROW_WIDTH);
    w[ROW_POS +: ROW_W] = pix_row[ROW_W-1:0];
    r.drive_word = w;
    r.row_end = (col == ROW_WIDTH - 1);
    r.frame_end = r.row_end && (pix_row == ROW_PAIRS - 1);
    return r;
  endfunction

  // Work out the words one accepted pair causes, then advance the scan
  task automatic predict_words(input in_item_t it);
    if ((pix_col % 2) == 0) begin
      held_pair_q = {it.bottom_color, it.upper_color};
      if (!(swap_cfg && pix_col + 1 < ROW_WIDTH))
        expected_words.push_back(build_word(pix_col, it.upper_color, it.bottom_color));
    end else if (swap_cfg) begin
      expected_words.push_back(build_word(pix_col - 1, it.upper_color, it.bottom_color));
      expected_words.push_back(build_word(pix_col, held_pair_q[15:0], held_pair_q[31:16]));
    end else begin
      expected_words.push_back(build_word(pix_col, it.upper_color, it.bottom_color));
    end
    pix_col++;
    if (pix_col >= ROW_WIDTH) begin
      pix_col = 0;
      pix_row++;
      if (pix_row >= ROW_PAIRS) begin
        pix_row = 0;
      end
    end
  endtask

  // Mix of black, random, single-field and single-bit colors
  function automatic logic [15:0] pick_color();
    logic [4:0]  five;
    logic [5:0]  six;
    logic [15:0] c;
    five = 5'($urandom_range(31, 1));
    six = 6'($urandom_range(63, 1));
    case ($urandom_range(4))
      0: c = '0;
      1, 2: c = 16'($urandom);
      3: begin
        case ($urandom_range(2))
          0: c = {five, 11'd0};
          1: c = {5'd0, six, 5'd0};
          default: c = {11'd0, five};
        endcase
      end
      default: c = 16'h0001 << $urandom_range(15);
    endcase
    return c;
  endfunction

  // Offer one pair, with random idle cycles first; returns at a falling edge
  task automatic send_pair(input logic [15:0] top, input logic [15:0] bot);
    in_item_t it;
    it.upper_color = top;
    it.bottom_color = bot;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_item = it;
    do @(posedge clk); while (in_full);
    predict_words(it);
    @(negedge clk);
    in_push = 1'b0;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pair(pick_color(), pick_color());
  endtask

  // Write one register; only called while the block is idle
  task automatic write_reg(input cfg_reg_t idx, input int value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = 8'(value);
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_BLANK_COLUMNS) blank_cfg = value & 6'h3F;
    else if (idx == CFG_SWAP_ADJACENT) swap_cfg = value[0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold until every expected word has arrived, then let the pipeline settle
  task automatic wait_drained();
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Field extremes and single bits of each color field, reset settings
  task automatic test_color_extremes();
    send_pair(16'h0000, 16'h0000);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'hF800, 16'h07E0);
    send_pair(16'h001F, 16'hF800);
    send_pair(16'h07E0, 16'h001F);
    send_pair(16'h0800, 16'h0020);
    send_pair(16'h0001, 16'h0001);
    send_pair(16'h8000, 16'h0400);
    send_pair(16'h0010, 16'hFFFF);
    send_pair(16'h0020, 16'h0000);
    send_pair(16'hAAAA, 16'h5555);
    send_pair(16'h5555, 16'hAAAA);
  endtask

  // Drop swapping with an even pair held, then raise it at an odd column
  task automatic test_swap_change_mid_pair();
    if ((pix_col % 2) != 0) send_pair(16'h1234, 16'h4321);
    send_pair(16'hF81F, 16'h07E0);
    wait_drained();
    write_reg(CFG_SWAP_ADJACENT, 0);
    send_pair(16'h001F, 16'h0000);
    send_pair(16'h0000, 16'hF800);
    send_pair(16'h07E0, 16'h07E0);
    send_pair(16'hF800, 16'h001F);
    wait_drained();
    write_reg(CFG_SWAP_ADJACENT, 1);
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'hFFFF, 16'h0000);
    wait_drained();
  endtask

  // Random pairs over several register settings, including the extremes
  task automatic test_random_traffic();
    int blanks[6];
    int swaps[6];
    blanks = '{0, 48, 4, 0, 47, 1};
    swaps = '{0, 1, 1, 0, 0, 1};
    for (int s = 0; s < 6; s++) begin
      wait_drained();
      if (s == 3) begin
        write_reg(CFG_BLANK_COLUMNS, $urandom_range(48));
        write_reg(CFG_SWAP_ADJACENT, $urandom_range(1));
      end else begin
        write_reg(CFG_BLANK_COLUMNS, blanks[s]);
        write_reg(CFG_SWAP_ADJACENT, swaps[s]);
      end
      send_random($urandom_range(48, 30));
    end
  endtask

  // Hold off the receiver while pairs keep coming, so the input stalls
  task automatic test_receiver_stall();
    set_idling(0, 0);
    hold_req = HOLD_OFF;
    send_random(60);
    wait_drained();
  endtask

  // Run to the end of a row so the column wraps and the row advances
  task automatic test_row_wrap();
    int start_row;
    set_idling(0, 0);
    wait_drained();
    write_reg(CFG_BLANK_COLUMNS, 4);
    write_reg(CFG_SWAP_ADJACENT, 1);
    start_row = pix_row;
    while (pix_row == start_row) send_pair(pick_color(), pick_color());
    send_random(24);
  endtask

  // Receiver: random pops, or a counted hold-off when requested
  initial begin
    int hold_left;
    hold_left = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop = 1'b0;
      end else begin
        out_pop = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each transfer on the result side with the oldest expectation
  always @(posedge clk) begin
    out_item_t exp_w;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual %h", $time, out_item);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_item.drive_word !== exp_w.drive_word) begin
          $display("%0t: drive_word mismatch: expected %h, actual %h",
                   $time, exp_w.drive_word, out_item.drive_word);
          errors++;
        end
        if (out_item.row_end !== exp_w.row_end) begin
          $display("%0t: row_end mismatch: expected %b, actual %b",
                   $time, exp_w.row_end, out_item.row_end);
          errors++;
        end
        if (out_item.frame_end !== exp_w.frame_end) begin
          $display("%0t: frame_end mismatch: expected %b, actual %b",
                   $time, exp_w.frame_end, out_item.frame_end);
          errors++;
        end
      end
    end
  end

  // End the run when no transfer of any kind happens for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d words outstanding", $time,
                 expected_words.size());
        $display("led_matrix_scan_word_formatter_unit_test: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_BLANK_COLUMNS;
    cfg_data = '0;
    errors = 0;
    hold_req = 0;
    pix_col = 0;
    pix_row = 0;
    held_pair_q = '0;
    blank_cfg = BLANK_RESET;
    swap_cfg = SWAP_RESET;
    set_idling(0, 0);
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_color_extremes();
    test_swap_change_mid_pair();
    set_idling(27, 86);
    test_random_traffic();
    set_idling(86, 27);
    test_random_traffic();
    set_idling(0, 0);
    test_random_traffic();
    test_receiver_stall();
    test_row_wrap();
    wait_drained();

    if (errors == 0 && expected_words.size() == 0) begin
      $display("led_matrix_scan_word_formatter_unit_test: done, clean");
    end else begin
      $display("led_matrix_scan_word_formatter_unit_test: done, errors");
    end
    $finish;
  end

endmodule
